@@ rtl/cat_map_frame_permuter_core_assert.svh @@
// Assertion macros shared by the cat map frame permuter modules.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef CAT_MAP_FRAME_PERMUTER_CORE_ASSERT_SVH
`define CAT_MAP_FRAME_PERMUTER_CORE_ASSERT_SVH

// Same-cycle implication.
`define CMFP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CMFP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cmfp_pkg.sv @@
// Shared types and constants for the cat map frame permuter.
// No dependencies; used by cmfp_ctrl, cmfp_datapath and the top level.
package cmfp_pkg;

    localparam int MAX_SIDE = 64;
    localparam int COORD_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W   = COORD_W + 1;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W   = 2 * COORD_W;
    localparam int PIX_W    = 8;
    localparam int STEP_W   = 8;
    localparam int REQ_W    = 2;
    localparam int CFG_W    = 7;
    localparam int CFG_RST  = 64;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_XFORM = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PASS,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic latch_req;   // capture input item
        logic wr_pix;      // pixel write into live bank
        logic rd_pix;      // pixel read from live bank
        logic pass_init;   // clear scan counters
        logic pass_issue;  // read one source pixel, schedule its scatter
        logic pass_swap;   // end of pass: swap banks, count down passes
        logic load_out;    // load result register
    } t_dp_cmd;

    typedef struct packed {
        t_req req;
        logic in_range;
        logic last_elem;
        logic last_pass;
        logic out_free;
    } t_dp_sts;

endpackage

@@ rtl/cmfp_ctrl.sv @@
// Sequencer for the cat map frame permuter.
// Depends on cmfp_pkg and the assertion macro header.
`include "cat_map_frame_permuter_core_assert.svh"

module cmfp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  cmfp_pkg::t_dp_sts i_sts,
    output cmfp_pkg::t_dp_cmd o_cmd
);
    import cmfp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.latch_req = 1'b1;
                    n_state         = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_FINISH;
                case (i_sts.req)
                    REQ_WRITE: o_cmd.wr_pix = i_sts.in_range;
                    REQ_READ:  o_cmd.rd_pix = i_sts.in_range;
                    REQ_XFORM: begin
                        o_cmd.pass_init = 1'b1;
                        n_state         = ST_PASS;
                    end
                    default: n_state = ST_FINISH;
                endcase
            end
            ST_PASS: begin
                o_cmd.pass_issue = 1'b1;
                if (i_sts.last_elem) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last scatter write lands at this edge, together with the swap
                o_cmd.pass_swap = 1'b1;
                if (i_sts.last_pass) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.pass_init = 1'b1;
                    n_state         = ST_PASS;
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `CMFP_ASSERT_NXT(a_accept_decode, i_in_valid && !o_in_stall, r_state == ST_DECODE,
        "accepted item did not reach decode")
    `CMFP_ASSERT_IMP(a_load_free, o_cmd.load_out, i_sts.out_free,
        "result loaded while output slot busy")
    `CMFP_ASSERT_NXT(a_last_pass_done, r_state == ST_DRAIN && i_sts.last_pass,
        r_state == ST_FINISH, "transform did not finish after last pass")
    `CMFP_ASSERT_IMP(a_mem_excl, o_cmd.wr_pix, !o_cmd.rd_pix && !o_cmd.pass_issue,
        "pixel write overlaps another memory access")

endmodule

@@ rtl/cmfp_datapath.sv @@
// Datapath: two frame banks, scan counters, request and result registers.
// Depends on cmfp_pkg and the assertion macro header.
`include "cat_map_frame_permuter_core_assert.svh"

module cmfp_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [cmfp_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic [cmfp_pkg::REQ_W-1:0]   i_req_type,
    input  logic [cmfp_pkg::COORD_W-1:0] i_row,
    input  logic [cmfp_pkg::COORD_W-1:0] i_col,
    input  logic [cmfp_pkg::PIX_W-1:0]   i_pixel_value,
    input  logic [cmfp_pkg::STEP_W-1:0]  i_step_count,
    input  cmfp_pkg::t_dp_cmd            i_cmd,
    output cmfp_pkg::t_dp_sts            o_sts,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [cmfp_pkg::PIX_W-1:0]   o_read_value,
    output logic                         o_transform_done,
    output logic                         o_out_of_range
);
    import cmfp_pkg::*;

    logic [PIX_W-1:0] mem0 [DEPTH];
    logic [PIX_W-1:0] mem1 [DEPTH];

    logic [CFG_W-1:0]   r_matrix_size;
    logic               r_bank;
    t_req               r_req;
    logic [COORD_W-1:0] r_row, r_col;
    logic [PIX_W-1:0]   r_pix;
    logic [STEP_W-1:0]  r_steps;
    logic [COORD_W-1:0] r_i, r_j, r_x, r_y;
    logic               r_wr_valid;
    logic [ADDR_W-1:0]  r_wr_addr;
    logic [PIX_W-1:0]   r_rdata0, r_rdata1;
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_out_read;
    logic               r_out_done, r_out_oor;

    logic [SIDE_W-1:0]  side, side_m1;
    logic               in_range;
    logic               row_end;
    logic [SIDE_W-1:0]  x_inc, y_p2, y_s1, y_s2;
    logic [COORD_W-1:0] x_nxt, y_nxt;
    logic [COORD_W-1:0] i_inc;
    logic [PIX_W-1:0]   src_data;
    logic               rd_en, we0, we1;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;
    logic [PIX_W-1:0]   wr_data;

    // side in use, clamped to 1..MAX_SIDE
    always_comb begin
        if (r_matrix_size == '0) begin
            side = SIDE_W'(1);
        end else if (SIDE_W'(r_matrix_size) > SIDE_W'(MAX_SIDE)) begin
            side = SIDE_W'(MAX_SIDE);
        end else begin
            side = SIDE_W'(r_matrix_size);
        end
    end

    assign side_m1  = side - SIDE_W'(1);
    assign in_range = ({1'b0, r_row} < side) && ({1'b0, r_col} < side);
    assign row_end  = ({1'b0, r_j} == side_m1);

    // destination steps: x += 1, y += 2, both mod side
    assign x_inc = {1'b0, r_x} + SIDE_W'(1);
    assign x_nxt = (x_inc == side) ? '0 : x_inc[COORD_W-1:0];
    assign y_p2  = {1'b0, r_y} + SIDE_W'(2);
    assign y_s1  = (y_p2 >= side) ? (y_p2 - side) : y_p2;
    assign y_s2  = (y_s1 >= side) ? (y_s1 - side) : y_s1;
    assign y_nxt = y_s2[COORD_W-1:0];
    assign i_inc = r_i + COORD_W'(1);

    // reads always come from the live bank
    assign src_data = r_bank ? r_rdata1 : r_rdata0;
    assign rd_en    = i_cmd.rd_pix | i_cmd.pass_issue;
    assign rd_addr  = i_cmd.rd_pix ? {r_row, r_col} : {r_i, r_j};
    assign wr_addr  = i_cmd.wr_pix ? {r_row, r_col} : r_wr_addr;
    assign wr_data  = i_cmd.wr_pix ? r_pix : src_data;
    assign we0      = (i_cmd.wr_pix && !r_bank) || (r_wr_valid && r_bank);
    assign we1      = (i_cmd.wr_pix && r_bank) || (r_wr_valid && !r_bank);

    always_ff @(posedge i_clk) begin
        if (we0) begin
            mem0[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata0 <= mem0[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we1) begin
            mem1[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata1 <= mem1[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= CFG_W'(CFG_RST);
            r_bank        <= 1'b0;
            r_wr_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_matrix_size <= i_cfg_wdata;
            end
            if (i_cmd.pass_swap) begin
                r_bank <= ~r_bank;
            end
            r_wr_valid <= i_cmd.pass_issue;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_req   <= t_req'(i_req_type);
            r_row   <= i_row;
            r_col   <= i_col;
            r_pix   <= i_pixel_value;
            r_steps <= (i_step_count == '0) ? STEP_W'(1) : i_step_count;
        end else if (i_cmd.pass_swap) begin
            r_steps <= r_steps - STEP_W'(1);
        end
        if (i_cmd.pass_init) begin
            r_i <= '0;
            r_j <= '0;
            r_x <= '0;
            r_y <= '0;
        end else if (i_cmd.pass_issue) begin
            if (row_end) begin
                r_i <= i_inc;
                r_j <= '0;
                r_x <= i_inc;
                r_y <= i_inc;
            end else begin
                r_j <= r_j + COORD_W'(1);
                r_x <= x_nxt;
                r_y <= y_nxt;
            end
        end
        if (i_cmd.pass_issue) begin
            r_wr_addr <= {r_x, r_y};
        end
        if (i_cmd.load_out) begin
            r_out_read <= (r_req == REQ_READ && in_range) ? src_data : '0;
            r_out_done <= (r_req == REQ_XFORM);
            r_out_oor  <= (r_req inside {REQ_WRITE, REQ_READ}) && !in_range;
        end
    end

    always_comb begin
        o_sts.req       = r_req;
        o_sts.in_range  = in_range;
        o_sts.last_elem = row_end && ({1'b0, r_i} == side_m1);
        o_sts.last_pass = (r_steps == STEP_W'(1));
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_value     = r_out_read;
    assign o_transform_done = r_out_done;
    assign o_out_of_range   = r_out_oor;

    `CMFP_ASSERT_IMP(a_no_overrun, i_cmd.load_out, !r_out_valid || !i_out_stall,
        "result register overwritten before taken")
    `CMFP_ASSERT_IMP(a_dst_range, i_cmd.pass_issue,
        ({1'b0, r_x} < side) && ({1'b0, r_y} < side), "scatter target outside frame")
    `CMFP_ASSERT_IMP(a_result_excl, r_out_valid, !(r_out_done && r_out_oor),
        "transform result flagged out of range")

endmodule

@@ rtl/cat_map_frame_permuter_core.sv @@
// Cat map frame permuter, top level.
// Instantiates cmfp_ctrl and cmfp_datapath; depends on cmfp_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall): one item per request. req_type
//   0 writes pixel_value at (row, col), 2 reads (row, col), 1 applies the
//   cat map (i,j) -> ((i+j) mod N, (i+2j) mod N) step_count times (0 = once).
//   Output channel (o_out_valid / i_out_stall): exactly one result item per
//   input item, in order. out_of_range flags a write/read with row or col >= N
//   (write dropped, read gives 0). transform_done marks a finished transform.
//   Config: i_cfg_we loads matrix_size (N), clamped to 1..64; write only idle.
// Sequence: write/read/unused code = accept, decode, then load of the result.
//   Transform = accept, decode, P passes, then load: the scan issues one pixel
//   a cycle from the live bank's read port while the other bank's write port
//   takes the scatter, and each pass ends in a drain state.
// Flow: one item at a time (accept, decode, load) outside transforms;
//   the input stalls until the result is loaded into the output register, and
//   the next item is taken while that result waits; a stalled output holds it.
// Reset: synchronous, active low; N = 64, live bank = bank 0. Frame contents
//   are undefined until written; no clearing pass is run.
module cat_map_frame_permuter_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [cmfp_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [cmfp_pkg::REQ_W-1:0]   i_req_type,
    input  logic [cmfp_pkg::COORD_W-1:0] i_row,
    input  logic [cmfp_pkg::COORD_W-1:0] i_col,
    input  logic [cmfp_pkg::PIX_W-1:0]   i_pixel_value,
    input  logic [cmfp_pkg::STEP_W-1:0]  i_step_count,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [cmfp_pkg::PIX_W-1:0]   o_read_value,
    output logic                         o_transform_done,
    output logic                         o_out_of_range
);
    import cmfp_pkg::*;

    // command / status bundle between sequencer and datapath
    t_dp_cmd cmd;
    t_dp_sts sts;

    cmfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cmfp_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_req_type       (i_req_type),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_pixel_value    (i_pixel_value),
        .i_step_count     (i_step_count),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_read_value     (o_read_value),
        .o_transform_done (o_transform_done),
        .o_out_of_range   (o_out_of_range)
    );

endmodule
